// ----- hdl/frpd_pkg.sv -----
// Package for the fault recovery policy decision block.
// Holds the episode and decision types and the action, variant and reason codes.
// No dependencies.
package frpd_pkg;

    // Recovery actions.
    localparam logic [2:0] REC_NONE     = 3'd0;
    localparam logic [2:0] REC_RETRY    = 3'd1;
    localparam logic [2:0] REC_REINIT   = 3'd2;
    localparam logic [2:0] REC_DEGRADE  = 3'd3;
    localparam logic [2:0] REC_ESCALATE = 3'd4;

    // Association levels.
    localparam logic [1:0] LVL_EXACT   = 2'd0;
    localparam logic [1:0] LVL_UNKNOWN = 2'd3;

    // Policy variants.
    localparam logic [2:0] VAR_FIXED_RETRY = 3'd0;
    localparam logic [2:0] VAR_RETRY_RECOV = 3'd1;
    localparam logic [2:0] VAR_CONTEXT     = 3'd2;
    localparam logic [2:0] VAR_CTX_HISTORY = 3'd3;
    localparam logic [2:0] VAR_INTEGRATED  = 3'd4;

    // Attempt thresholds.
    localparam logic [7:0] ATT_TWO   = 8'd2;
    localparam logic [7:0] ATT_THREE = 8'd3;

    // Reason codes, one per rule.
    localparam logic [7:0] RSN_NO_ACTION       = 8'd0;
    localparam logic [7:0] RSN_FIX_RETRY       = 8'd1;
    localparam logic [7:0] RSN_FIX_ESCALATE    = 8'd2;
    localparam logic [7:0] RSN_RR_RETRY        = 8'd3;
    localparam logic [7:0] RSN_RR_REINIT       = 8'd4;
    localparam logic [7:0] RSN_RR_DEGRADE      = 8'd5;
    localparam logic [7:0] RSN_RR_ESCALATE     = 8'd6;
    localparam logic [7:0] RSN_CTX_UNSAFE      = 8'd7;
    localparam logic [7:0] RSN_CTX_BUS_REINIT  = 8'd8;
    localparam logic [7:0] RSN_CTX_RETRY       = 8'd9;
    localparam logic [7:0] RSN_CTX_DEGRADE     = 8'd10;
    localparam logic [7:0] RSN_CTX_ESCALATE    = 8'd11;
    localparam logic [7:0] RSN_HIST_UNSAFE     = 8'd12;
    localparam logic [7:0] RSN_HIST_REINIT     = 8'd13;
    localparam logic [7:0] RSN_HIST_RETRY      = 8'd14;
    localparam logic [7:0] RSN_HIST_DEGRADE    = 8'd15;
    localparam logic [7:0] RSN_HIST_ESCALATE   = 8'd16;
    localparam logic [7:0] RSN_INT_NOT_EXACT   = 8'd17;
    localparam logic [7:0] RSN_INT_AMBIGUOUS   = 8'd18;
    localparam logic [7:0] RSN_INT_UNSAFE      = 8'd19;
    localparam logic [7:0] RSN_INT_EXHAUSTED   = 8'd20;
    localparam logic [7:0] RSN_INT_LATE        = 8'd21;
    localparam logic [7:0] RSN_INT_RETRY       = 8'd22;
    localparam logic [7:0] RSN_INT_REINIT      = 8'd23;
    localparam logic [7:0] RSN_INT_DEGRADE     = 8'd24;
    localparam logic [7:0] RSN_INT_ESCALATE    = 8'd25;
    localparam logic [7:0] RSN_BAD_VARIANT     = 8'd255;

    // Packed widths of the stream payloads.
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 16;

    // One fault episode context.
    typedef struct packed {
        logic       episode_active;
        logic       episode_terminal;
        logic [1:0] association;
        logic [7:0] attempts;
        logic       retry_ok;
        logic       reinit_ok;
        logic       degrade_ok;
        logic       deps_safe;
        logic       shared_valid;
        logic       persistent_bus_fault;
    } t_episode;

    // One recovery decision.
    typedef struct packed {
        logic [2:0] action;
        logic       is_terminal;
        logic       retry_granted;
        logic [7:0] rule_id;
        logic [1:0] scope_level;
    } t_decision;

endpackage

// ----- hdl/frpd_decide.sv -----
// Decision logic of the fault recovery policy block.
// Maps one registered episode context and the policy variant to a decision.
// Depends on frpd_pkg.
module frpd_decide
    import frpd_pkg::*;
(
    input  logic [2:0] i_variant,
    input  t_episode   i_episode,
    output t_decision  o_decision
);

    logic       w_unsafe_ctx;
    logic       w_amb;
    logic       w_lt2;
    logic       w_lt3;
    logic [2:0] w_deg_or_esc;

    // Shared conditions used by several variants.
    assign w_amb        = (i_episode.association == LVL_UNKNOWN);
    assign w_unsafe_ctx = w_amb || !i_episode.deps_safe || !i_episode.shared_valid;
    assign w_lt2        = (i_episode.attempts < ATT_TWO);
    assign w_lt3        = (i_episode.attempts < ATT_THREE);
    assign w_deg_or_esc = i_episode.degrade_ok ? REC_DEGRADE : REC_ESCALATE;

    // Rule table per variant; the first matching rule wins.
    always_comb begin
        o_decision                  = '0;
        o_decision.scope_level      = i_episode.association;
        o_decision.action           = REC_NONE;
        o_decision.rule_id          = RSN_NO_ACTION;
        if (i_episode.episode_active && !i_episode.episode_terminal) begin
            case (i_variant)
                VAR_FIXED_RETRY: begin
                    if (w_lt2) begin
                        o_decision.action        = REC_RETRY;
                        o_decision.retry_granted = 1'b1;
                        o_decision.rule_id       = RSN_FIX_RETRY;
                    end else begin
                        o_decision.action      = REC_ESCALATE;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_FIX_ESCALATE;
                    end
                end
                VAR_RETRY_RECOV: begin
                    if (w_lt2 && i_episode.retry_ok) begin
                        o_decision.action        = REC_RETRY;
                        o_decision.retry_granted = 1'b1;
                        o_decision.rule_id       = RSN_RR_RETRY;
                    end else if (i_episode.reinit_ok && w_lt3) begin
                        o_decision.action  = REC_REINIT;
                        o_decision.rule_id = RSN_RR_REINIT;
                    end else if (i_episode.degrade_ok) begin
                        o_decision.action      = REC_DEGRADE;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_RR_DEGRADE;
                    end else begin
                        o_decision.action      = REC_ESCALATE;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_RR_ESCALATE;
                    end
                end
                VAR_CONTEXT: begin
                    if (w_unsafe_ctx) begin
                        o_decision.action      = w_deg_or_esc;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_CTX_UNSAFE;
                    end else if (i_episode.persistent_bus_fault && i_episode.reinit_ok) begin
                        o_decision.action  = REC_REINIT;
                        o_decision.rule_id = RSN_CTX_BUS_REINIT;
                    end else if (i_episode.retry_ok) begin
                        o_decision.action        = REC_RETRY;
                        o_decision.retry_granted = 1'b1;
                        o_decision.rule_id       = RSN_CTX_RETRY;
                    end else if (i_episode.degrade_ok) begin
                        o_decision.action      = REC_DEGRADE;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_CTX_DEGRADE;
                    end else begin
                        o_decision.action      = REC_ESCALATE;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_CTX_ESCALATE;
                    end
                end
                VAR_CTX_HISTORY: begin
                    if (w_unsafe_ctx) begin
                        o_decision.action      = w_deg_or_esc;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_HIST_UNSAFE;
                    end else if (!w_lt2 && i_episode.reinit_ok) begin
                        o_decision.action  = REC_REINIT;
                        o_decision.rule_id = RSN_HIST_REINIT;
                    end else if (i_episode.retry_ok && w_lt2) begin
                        o_decision.action        = REC_RETRY;
                        o_decision.retry_granted = 1'b1;
                        o_decision.rule_id       = RSN_HIST_RETRY;
                    end else if (i_episode.degrade_ok) begin
                        o_decision.action      = REC_DEGRADE;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_HIST_DEGRADE;
                    end else begin
                        o_decision.action      = REC_ESCALATE;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_HIST_ESCALATE;
                    end
                end
                VAR_INTEGRATED: begin
                    if (i_episode.association != LVL_EXACT) begin
                        o_decision.action      = REC_ESCALATE;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_INT_NOT_EXACT;
                    end else if (w_amb && !i_episode.degrade_ok) begin
                        // Ambiguity rule: the rule above already catches an unknown
                        // association, so this one never fires.
                        o_decision.action      = REC_ESCALATE;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_INT_AMBIGUOUS;
                    end else if (!i_episode.deps_safe || !i_episode.shared_valid) begin
                        o_decision.action      = w_deg_or_esc;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_INT_UNSAFE;
                    end else if (!w_lt3) begin
                        o_decision.action      = w_deg_or_esc;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_INT_EXHAUSTED;
                    end else if (!w_lt2) begin
                        // Reinit if allowed; otherwise the episode ends.
                        o_decision.action      = i_episode.reinit_ok ? REC_REINIT : w_deg_or_esc;
                        o_decision.is_terminal = !i_episode.reinit_ok;
                        o_decision.rule_id     = RSN_INT_LATE;
                    end else if (i_episode.retry_ok) begin
                        o_decision.action        = REC_RETRY;
                        o_decision.retry_granted = 1'b1;
                        o_decision.rule_id       = RSN_INT_RETRY;
                    end else if (i_episode.reinit_ok) begin
                        o_decision.action  = REC_REINIT;
                        o_decision.rule_id = RSN_INT_REINIT;
                    end else if (i_episode.degrade_ok) begin
                        o_decision.action      = REC_DEGRADE;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_INT_DEGRADE;
                    end else begin
                        o_decision.action      = REC_ESCALATE;
                        o_decision.is_terminal = 1'b1;
                        o_decision.rule_id     = RSN_INT_ESCALATE;
                    end
                end
                default: begin
                    o_decision.action      = REC_ESCALATE;
                    o_decision.is_terminal = 1'b1;
                    o_decision.rule_id     = RSN_BAD_VARIANT;
                end
            endcase
        end
    end

endmodule

// ----- hdl/fault_recovery_policy_decision.sv -----
// Top level of the fault recovery policy decision block.
// Holds the input register, the result register and the policy register.
// Depends on frpd_pkg and frpd_decide.

// Each transfer on the slave stream carries one fault episode context and
// yields exactly one decision transfer on the master stream. The block takes
// one item per clock cycle while the master side does not stall; a decision
// passes through the input register and then the result register, with the
// rule table in between. Both registers hold while the master side
// stalls, so no item is lost. The policy variant register is written through
// the configuration channel, which is always ready; write it only while no
// item is in flight.
module fault_recovery_policy_decision
    import frpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Configuration channel: policy_variant in bits [2:0].
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_data,

    // Episode stream. tdata from bit 0: episode_active, episode_terminal,
    // association[1:0], attempts[7:0], retry_ok, reinit_ok, degrade_ok,
    // deps_safe, shared_valid, persistent_bus_fault, zero fill.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    // Decision stream. tdata from bit 0: action[2:0], is_terminal,
    // retry_granted, rule_id[7:0], scope_level[1:0], zero fill.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [2:0] r_variant;
    logic       r_in_valid;
    logic       n_in_valid;
    t_episode   r_in;
    t_episode   w_episode;
    logic       r_out_valid;
    logic       n_out_valid;
    t_decision  r_out;
    t_decision  w_decision;
    logic       w_adv;

    // Unpack the incoming transfer into the episode fields.
    assign w_episode.episode_active       = s_axis_tdata[0];
    assign w_episode.episode_terminal     = s_axis_tdata[1];
    assign w_episode.association          = s_axis_tdata[3:2];
    assign w_episode.attempts             = s_axis_tdata[11:4];
    assign w_episode.retry_ok             = s_axis_tdata[12];
    assign w_episode.reinit_ok            = s_axis_tdata[13];
    assign w_episode.degrade_ok           = s_axis_tdata[14];
    assign w_episode.deps_safe            = s_axis_tdata[15];
    assign w_episode.shared_valid         = s_axis_tdata[16];
    assign w_episode.persistent_bus_fault = s_axis_tdata[17];

    // Policy register; the channel never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= VAR_FIXED_RETRY;
        end else if (i_cfg_valid) begin
            r_variant <= i_cfg_data;
        end
    end

    // Pipeline control: the input stage moves when the result stage is free.
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign n_in_valid    = s_axis_tready ? s_axis_tvalid : r_in_valid;
    assign n_out_valid   = w_adv ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= w_episode;
        end
        if (w_adv && r_in_valid) begin
            r_out <= w_decision;
        end
    end

    // Rule table between the two registers.
    frpd_decide u_decide (
        .i_variant  (r_variant),
        .i_episode  (r_in),
        .o_decision (w_decision)
    );

    // Pack the decision for the master stream.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.scope_level, r_out.rule_id,
                            r_out.retry_granted, r_out.is_terminal, r_out.action};

    // A retry authorization only comes with a retry action.
    a_retry_auth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.retry_granted) |-> (r_out.action == REC_RETRY))
        else $error("retry authorized without retry action");

    // Reason zero is the no-action decision and never ends the episode.
    a_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.rule_id == RSN_NO_ACTION)) |->
        ((r_out.action == REC_NONE) && !r_out.is_terminal))
        else $error("reason zero with an action");

    // Escalation and degrade always end the episode.
    a_terminal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out.action == REC_ESCALATE) || (r_out.action == REC_DEGRADE)))
        |-> r_out.is_terminal)
        else $error("terminal action not flagged terminal");

    // A held input item stays put until the result stage frees up.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in)))
        else $error("input stage lost an item while stalled");

endmodule

// ----- verif/tb_fault_recovery_policy_decision.sv -----
// Self-checking testbench for the fault recovery policy decision block.
// Drives episode contexts through the slave stream under every policy variant and checks
// each decision against an in-bench predictor. Depends on frpd_pkg and the block's top level.
`timescale 1ns / 1ps

module tb_fault_recovery_policy_decision;
    import frpd_pkg::*;

    // Association levels and policy variants that the package leaves unnamed.
    localparam logic [1:0] LVL_TRANSACTION = 2'd1;
    localparam logic [1:0] LVL_SERVICE     = 2'd2;
    localparam logic [2:0] VAR_UNDEF_A     = 3'd5;
    localparam logic [2:0] VAR_UNDEF_B     = 3'd6;
    localparam logic [2:0] VAR_UNDEF_C     = 3'd7;

    localparam int RESET_CYCLES   = 7;
    localparam int ITEMS_PER_SET  = 50;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_REPORTS    = 10;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [2:0]             i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    t_episode  pending_episodes[$];
    t_decision expected_decisions[$];
    t_episode  offered;
    t_decision got;
    t_decision want;
    logic [2:0] policy_shadow;
    int        fail_count = 0;
    int        cycle_count = 0;
    int        burst_left;
    int        gap_left;
    int        hold_left;
    int        mode_left;
    int        ready_mode;
    logic      ready_next;
    logic      long_hold_req = 1'b0;
    logic      long_hold_done;

    fault_recovery_policy_decision u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Builds one decision without its scope.
    function automatic t_decision verdict(input logic [2:0] act, input logic term,
                                          input logic retry, input logic [7:0] rsn);
        t_decision d;
        d.action        = act;
        d.is_terminal   = term;
        d.retry_granted = retry;
        d.rule_id       = rsn;
        d.scope_level   = LVL_EXACT;
        return d;
    endfunction

    // Rule table of every policy variant.
    function automatic t_decision decide_recovery(input t_episode e, input logic [2:0] variant);
        t_decision  d;
        logic       unsafe_ctx;
        logic       early;
        logic [2:0] fallback;
        logic [2:0] late_act;
        unsafe_ctx = (e.association == LVL_UNKNOWN) || !e.deps_safe || !e.shared_valid;
        early      = e.attempts < ATT_TWO;
        fallback   = e.degrade_ok ? REC_DEGRADE : REC_ESCALATE;
        late_act   = e.reinit_ok ? REC_REINIT : fallback;
        if (!e.episode_active || e.episode_terminal) begin
            d = verdict(REC_NONE, 1'b0, 1'b0, RSN_NO_ACTION);
        end else begin
            case (variant)
                VAR_FIXED_RETRY: begin
                    if (early) d = verdict(REC_RETRY, 1'b0, 1'b1, RSN_FIX_RETRY);
                    else       d = verdict(REC_ESCALATE, 1'b1, 1'b0, RSN_FIX_ESCALATE);
                end
                VAR_RETRY_RECOV: begin
                    if (early && e.retry_ok)
                        d = verdict(REC_RETRY, 1'b0, 1'b1, RSN_RR_RETRY);
                    else if (e.reinit_ok && e.attempts < ATT_THREE)
                        d = verdict(REC_REINIT, 1'b0, 1'b0, RSN_RR_REINIT);
                    else if (e.degrade_ok)
                        d = verdict(REC_DEGRADE, 1'b1, 1'b0, RSN_RR_DEGRADE);
                    else
                        d = verdict(REC_ESCALATE, 1'b1, 1'b0, RSN_RR_ESCALATE);
                end
                VAR_CONTEXT: begin
                    if (unsafe_ctx)
                        d = verdict(fallback, 1'b1, 1'b0, RSN_CTX_UNSAFE);
                    else if (e.persistent_bus_fault && e.reinit_ok)
                        d = verdict(REC_REINIT, 1'b0, 1'b0, RSN_CTX_BUS_REINIT);
                    else if (e.retry_ok)
                        d = verdict(REC_RETRY, 1'b0, 1'b1, RSN_CTX_RETRY);
                    else if (e.degrade_ok)
                        d = verdict(REC_DEGRADE, 1'b1, 1'b0, RSN_CTX_DEGRADE);
                    else
                        d = verdict(REC_ESCALATE, 1'b1, 1'b0, RSN_CTX_ESCALATE);
                end
                VAR_CTX_HISTORY: begin
                    if (unsafe_ctx)
                        d = verdict(fallback, 1'b1, 1'b0, RSN_HIST_UNSAFE);
                    else if (!early && e.reinit_ok)
                        d = verdict(REC_REINIT, 1'b0, 1'b0, RSN_HIST_REINIT);
                    else if (e.retry_ok && early)
                        d = verdict(REC_RETRY, 1'b0, 1'b1, RSN_HIST_RETRY);
                    else if (e.degrade_ok)
                        d = verdict(REC_DEGRADE, 1'b1, 1'b0, RSN_HIST_DEGRADE);
                    else
                        d = verdict(REC_ESCALATE, 1'b1, 1'b0, RSN_HIST_ESCALATE);
                end
                VAR_INTEGRATED: begin
                    // The ambiguity rule sits behind the exact-association check and never fires.
                    if (e.association != LVL_EXACT)
                        d = verdict(REC_ESCALATE, 1'b1, 1'b0, RSN_INT_NOT_EXACT);
                    else if (e.association == LVL_UNKNOWN && !e.degrade_ok)
                        d = verdict(REC_ESCALATE, 1'b1, 1'b0, RSN_INT_AMBIGUOUS);
                    else if (!e.deps_safe || !e.shared_valid)
                        d = verdict(fallback, 1'b1, 1'b0, RSN_INT_UNSAFE);
                    else if (e.attempts >= ATT_THREE)
                        d = verdict(fallback, 1'b1, 1'b0, RSN_INT_EXHAUSTED);
                    else if (!early)
                        d = verdict(late_act, late_act >= REC_DEGRADE, 1'b0, RSN_INT_LATE);
                    else if (e.retry_ok)
                        d = verdict(REC_RETRY, 1'b0, 1'b1, RSN_INT_RETRY);
                    else if (e.reinit_ok)
                        d = verdict(REC_REINIT, 1'b0, 1'b0, RSN_INT_REINIT);
                    else if (e.degrade_ok)
                        d = verdict(REC_DEGRADE, 1'b1, 1'b0, RSN_INT_DEGRADE);
                    else
                        d = verdict(REC_ESCALATE, 1'b1, 1'b0, RSN_INT_ESCALATE);
                end
                default: begin
                    d = verdict(REC_ESCALATE, 1'b1, 1'b0, RSN_BAD_VARIANT);
                end
            endcase
        end
        d.scope_level = e.association;
        return d;
    endfunction

    function automatic t_episode episode_of(input logic active, input logic term,
                                            input logic [1:0] assoc, input logic [7:0] att,
                                            input logic rok, input logic iok, input logic dok,
                                            input logic deps, input logic shared,
                                            input logic pbus);
        t_episode e;
        e.episode_active       = active;
        e.episode_terminal     = term;
        e.association          = assoc;
        e.attempts             = att;
        e.retry_ok             = rok;
        e.reinit_ok            = iok;
        e.degrade_ok           = dok;
        e.deps_safe            = deps;
        e.shared_valid         = shared;
        e.persistent_bus_fault = pbus;
        return e;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("ERROR: %0s", msg);
    endtask

    // Returns at a rising edge once nothing is queued, offered or in flight.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_episodes.size() != 0 || s_axis_tvalid || expected_decisions.size() != 0);
    endtask

    // One transfer on the configuration channel; entered at a rising edge.
    task automatic write_policy(input logic [2:0] variant);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= variant;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Shadow of the policy register.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            policy_shadow <= VAR_FIXED_RETRY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            policy_shadow <= i_cfg_data;
        end
    end

    // Episode driver: bursts of transfers with random gaps in between.
    // An item leaves the queue only when its transfer completes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_decisions.push_back(decide_recovery(offered, policy_shadow));
                pending_episodes.delete(0);
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left != 0 || pending_episodes.size() == 0) begin
                    if (gap_left != 0) gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    offered = pending_episodes[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(IN_TDATA_W - 18){1'b0}},
                                      offered.persistent_bus_fault, offered.shared_valid,
                                      offered.deps_safe, offered.degrade_ok,
                                      offered.reinit_ok, offered.retry_ok,
                                      offered.attempts, offered.association,
                                      offered.episode_terminal, offered.episode_active};
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Decision monitor and receiver stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left      = 0;
            mode_left      = 0;
            ready_mode     = 0;
            long_hold_done = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.action        = m_axis_tdata[2:0];
                got.is_terminal   = m_axis_tdata[3];
                got.retry_granted = m_axis_tdata[4];
                got.rule_id       = m_axis_tdata[12:5];
                got.scope_level   = m_axis_tdata[14:13];
                if (expected_decisions.size() == 0) begin
                    note_failure($sformatf("decision 0x%h arrived with none expected",
                                           m_axis_tdata));
                end else begin
                    want = expected_decisions.pop_front();
                    if (got.action != want.action || got.is_terminal != want.is_terminal ||
                        got.retry_granted != want.retry_granted ||
                        got.rule_id != want.rule_id ||
                        got.scope_level != want.scope_level) begin
                        note_failure($sformatf({"decision mismatch: expected act=%0d term=%0b ",
                            "retry=%0b reason=%0d scope=%0d, got act=%0d term=%0b retry=%0b ",
                            "reason=%0d scope=%0d"},
                            want.action, want.is_terminal, want.retry_granted,
                            want.rule_id, want.scope_level, got.action, got.is_terminal,
                            got.retry_granted, got.rule_id, got.scope_level));
                    end
                end
            end

            // One long hold-off while the sender keeps offering, then changing stall modes.
            if (long_hold_req && !long_hold_done) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 80);
                end
                mode_left--;
                case (ready_mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = ($urandom_range(0, 1) != 0);
                    2:       ready_next = ($urandom_range(0, 7) != 0);
                    default: ready_next = ((mode_left % 3) != 0);
                endcase
            end
            m_axis_tready <= ready_next;
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** fault_recovery_policy_decision: FAILED **");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        logic [2:0] set_variants[14];
        t_episode   ep;
        set_variants = '{VAR_FIXED_RETRY, VAR_INTEGRATED, VAR_RETRY_RECOV, VAR_CONTEXT,
                         VAR_UNDEF_C, VAR_CTX_HISTORY, VAR_INTEGRATED, VAR_UNDEF_A,
                         VAR_CONTEXT, VAR_UNDEF_B, VAR_RETRY_RECOV, VAR_CTX_HISTORY,
                         VAR_INTEGRATED, VAR_FIXED_RETRY};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset policy: inactive and terminal episodes, then the attempt threshold.
        pending_episodes.push_back(episode_of(1'b0, 1'b1, LVL_UNKNOWN, 8'd255,
                                              1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        pending_episodes.push_back(episode_of(1'b1, 1'b1, LVL_SERVICE, 8'd0,
                                              1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd1,
                                              1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_TRANSACTION, 8'd2,
                                              1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        wait_drained();

        // Retry and recovery ladder.
        write_policy(VAR_RETRY_RECOV);
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd1,
                                              1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd2,
                                              1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_SERVICE, 8'd3,
                                              1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd255,
                                              1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        wait_drained();

        // Context policy: unknown association, bus reinit, retry, degrade, escalate.
        write_policy(VAR_CONTEXT);
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_UNKNOWN, 8'd0,
                                              1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd0,
                                              1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd0,
                                              1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_TRANSACTION, 8'd0,
                                              1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd0,
                                              1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        wait_drained();

        // Context with history.
        write_policy(VAR_CTX_HISTORY);
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd0,
                                              1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd2,
                                              1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd0,
                                              1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd2,
                                              1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd1,
                                              1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        wait_drained();

        // Integrated policy, one episode per reachable rule.
        write_policy(VAR_INTEGRATED);
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_SERVICE, 8'd0,
                                              1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd0,
                                              1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd3,
                                              1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd2,
                                              1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd1,
                                              1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd0,
                                              1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd0,
                                              1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd0,
                                              1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        wait_drained();

        // Top variant code, which no policy claims.
        write_policy(VAR_UNDEF_C);
        pending_episodes.push_back(episode_of(1'b1, 1'b0, LVL_EXACT, 8'd0,
                                              1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        wait_drained();

        // Random sets, one variant each; mostly live episodes with small attempt counts.
        foreach (set_variants[s]) begin
            write_policy(set_variants[s]);
            for (int k = 0; k < ITEMS_PER_SET; k++) begin
                ep.episode_active   = ($urandom_range(0, 9) != 0);
                ep.episode_terminal = ($urandom_range(0, 9) == 0);
                if (set_variants[s] == VAR_INTEGRATED && $urandom_range(0, 3) != 0)
                    ep.association = LVL_EXACT;
                else
                    ep.association = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0)
                    ep.attempts = 8'($urandom_range(0, 255));
                else
                    ep.attempts = 8'($urandom_range(0, 4));
                ep.retry_ok             = 1'($urandom_range(0, 1));
                ep.reinit_ok            = 1'($urandom_range(0, 1));
                ep.degrade_ok           = 1'($urandom_range(0, 1));
                ep.deps_safe            = ($urandom_range(0, 4) != 0);
                ep.shared_valid         = ($urandom_range(0, 4) != 0);
                ep.persistent_bus_fault = 1'($urandom_range(0, 1));
                pending_episodes.push_back(ep);
            end
            if (s == 2) long_hold_req = 1'b1;
            wait_drained();
        end

        // Let any stray transfer show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_decisions.size() != 0) begin
            note_failure($sformatf("%0d decisions never arrived", expected_decisions.size()));
        end
        if (fail_count == 0) begin
            $display("** fault_recovery_policy_decision: PASSED **");
        end else begin
            $display("** fault_recovery_policy_decision: FAILED **");
        end
        $finish;
    end

endmodule
